/* rtl/rrss_pkg.sv */
// shared types and constants of the round-robin slice scheduler
// no dependencies; compiled first
package rrss_pkg;

	// default sizing of the process table
	localparam int MAX_PROCESSES_DEF = 16;
	localparam int TIME_WIDTH_DEF    = 16;

	// fixed field widths of the item and result words
	localparam int OP_W      = 2;
	localparam int CPU_W     = 16;
	localparam int PID_W     = 4;
	localparam int RUN_W     = 16;
	localparam int QUANTUM_W = 8;

	localparam logic [QUANTUM_W-1:0] QUANTUM_RST = 8'd2;

	// operation codes; the fourth code has no meaning
	typedef enum logic [OP_W-1:0] {
		OP_LOAD    = 2'd0,
		OP_RESTORE = 2'd1,
		OP_NEXT    = 2'd2
	} op_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RESTORE,
		ST_SCAN,
		ST_RESPOND
	} state_t;

	// one result word
	typedef struct packed {
		logic [PID_W-1:0] process_id;
		logic [RUN_W-1:0] run_time;
		logic             finished;
		logic             table_full;
	} res_t;

endpackage

/* rtl/rrss_in_if.sv */
// item channel of the scheduler: valid, ready and the item fields
// depends on rrss_pkg
interface rrss_in_if;
	import rrss_pkg::*;

	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [CPU_W-1:0] cpu_time;

	modport source (output valid, output operation, output cpu_time, input ready);
	modport sink (input valid, input operation, input cpu_time, output ready);
endinterface

/* rtl/rrss_out_if.sv */
// result channel of the scheduler: valid, ready and the result fields
// depends on rrss_pkg
interface rrss_out_if;
	import rrss_pkg::*;

	logic             valid;
	logic             ready;
	logic [PID_W-1:0] process_id;
	logic [RUN_W-1:0] run_time;
	logic             finished;
	logic             table_full;

	modport source (output valid, output process_id, output run_time, output finished,
		output table_full, input ready);
	modport sink (input valid, input process_id, input run_time, input finished,
		input table_full, output ready);
endinterface

/* rtl/rrss_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module rrss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/rrss_seq.sv */
// sequencer of the scheduler: operation fsm, table counters, ram access
// and read-modify-write of remaining times; depends on rrss_pkg
module rrss_seq #(
	parameter int MAX_PROCESSES = rrss_pkg::MAX_PROCESSES_DEF,
	parameter int TIME_WIDTH    = rrss_pkg::TIME_WIDTH_DEF,
	localparam int IW = $clog2(MAX_PROCESSES)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rrss_pkg::OP_W-1:0]      operation,
	input  logic [rrss_pkg::CPU_W-1:0]     cpu_time,
	input  logic [rrss_pkg::QUANTUM_W-1:0] quantum,
	input  logic                           out_free,
	output logic                           res_valid,
	output rrss_pkg::res_t                 res,
	output logic                           req_we,
	output logic                           rem_we,
	output logic [IW-1:0]                  wr_addr,
	output logic [TIME_WIDTH-1:0]          wr_data,
	output logic                           req_re,
	output logic                           rem_re,
	output logic [IW-1:0]                  rd_addr,
	input  logic [TIME_WIDTH-1:0]          req_rdata,
	input  logic [TIME_WIDTH-1:0]          rem_rdata
);
	import rrss_pkg::*;

	localparam int CW = $clog2(MAX_PROCESSES + 1);
	localparam int WW = (TIME_WIDTH > RUN_W) ? TIME_WIDTH : RUN_W;

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q;
	logic [IW-1:0]   scan_q;
	logic [IW-1:0]   pos_s1;
	logic [CW-1:0]   n_q;
	logic            pend_s1;
	res_t            res_q;
	res_t            res_d;

	logic            accept;
	op_t             op;
	logic            full;
	logic            count_zero;
	logic [IW-1:0]   start;
	logic            hit;
	logic            all_issued;
	logic            rs_more;
	logic [CW-1:0]   pos_inc;
	logic [IW-1:0]   pos_nxt;
	logic [IW-1:0]   scan_after;
	logic [WW-1:0]   rem_w;
	logic [WW-1:0]   q_w;
	logic [WW-1:0]   grant_w;
	logic [TIME_WIDTH-1:0] grant;

	// status of table and scan
	assign accept     = in_valid && in_ready;
	assign op         = op_t'(operation);
	assign full       = (count_q == CW'(MAX_PROCESSES));
	assign count_zero = (count_q == '0);
	assign start      = (CW'(scan_q) < count_q) ? scan_q : '0;
	assign hit        = (rem_rdata != '0);
	assign all_issued = (n_q == count_q);
	assign rs_more    = (n_q < count_q);

	// circular step over loaded entries, and where the next scan starts
	assign pos_inc    = CW'(pos_s1) + CW'(1);
	assign pos_nxt    = (pos_inc == count_q) ? '0 : pos_s1 + IW'(1);
	assign scan_after = (pos_inc >= CW'(MAX_PROCESSES)) ? '0 : pos_s1 + IW'(1);

	// slice granted: min(quantum, remaining)
	assign rem_w   = WW'(rem_rdata);
	assign q_w     = WW'(quantum);
	assign grant_w = (rem_w < q_w) ? rem_w : q_w;
	assign grant   = TIME_WIDTH'(grant_w);

	assign res = res_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op)
						OP_RESTORE: state_d = count_zero ? ST_RESPOND : ST_RESTORE;
						OP_NEXT:    state_d = count_zero ? ST_RESPOND : ST_SCAN;
						default:    state_d = ST_RESPOND;
					endcase
				end
			end
			ST_RESTORE: begin
				if (!rs_more && !pend_s1) begin
					state_d = ST_RESPOND;
				end
			end
			ST_SCAN: begin
				if (hit || all_issued) begin
					state_d = ST_RESPOND;
				end
			end
			ST_RESPOND: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs: handshake and ram access
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		req_we    = 1'b0;
		rem_we    = 1'b0;
		wr_addr   = pos_s1;
		wr_data   = rem_rdata - grant;
		req_re    = 1'b0;
		rem_re    = 1'b0;
		rd_addr   = pos_nxt;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					case (op)
						OP_LOAD: begin
							req_we  = !full;
							rem_we  = !full;
							wr_addr = count_q[IW-1:0];
							wr_data = TIME_WIDTH'(cpu_time);
						end
						OP_NEXT: begin
							rem_re  = !count_zero;
							rd_addr = start;
						end
						default: begin
						end
					endcase
				end
			end
			ST_RESTORE: begin
				// copy required into remaining, one entry a cycle
				req_re  = rs_more;
				rd_addr = n_q[IW-1:0];
				rem_we  = pend_s1;
				wr_data = req_rdata;
			end
			ST_SCAN: begin
				// write back the reduced time on a hit, else read on
				if (hit) begin
					rem_we = 1'b1;
				end else begin
					rem_re = !all_issued;
				end
			end
			ST_RESPOND: begin
				res_valid = out_free;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			scan_q  <= '0;
			pos_s1  <= '0;
			n_q     <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (op)
							OP_LOAD: begin
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
							end
							OP_RESTORE: begin
								n_q     <= '0;
								pend_s1 <= 1'b0;
							end
							OP_NEXT: begin
								pos_s1 <= start;
								n_q    <= CW'(1);
							end
							default: begin
							end
						endcase
					end
				end
				ST_RESTORE: begin
					pend_s1 <= rs_more;
					if (rs_more) begin
						pos_s1 <= n_q[IW-1:0];
						n_q    <= n_q + CW'(1);
					end
				end
				ST_SCAN: begin
					if (hit) begin
						scan_q <= scan_after;
					end else if (!all_issued) begin
						pos_s1 <= pos_nxt;
						n_q    <= n_q + CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// next value of the pending result word
	always_comb begin
		res_d = res_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_d = '0;
					case (op)
						OP_LOAD: begin
							if (full) begin
								res_d.table_full = 1'b1;
							end else begin
								res_d.process_id = PID_W'(count_q);
							end
						end
						OP_NEXT: begin
							res_d.finished = count_zero;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (hit) begin
					res_d.process_id = PID_W'(pos_s1);
					res_d.run_time   = RUN_W'(grant);
				end else if (all_issued) begin
					res_d.finished = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// pending result word
	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

endmodule

/* rtl/round_robin_slice_scheduler_unit.sv */
// Round-robin time-slice scheduler. Keeps a table of up to MAX_PROCESSES
// processes in two rams (required and remaining time). Load appends an entry
// and returns its id, or table_full when the table holds MAX_PROCESSES entries.
// Restore copies every required time back into remaining time. Next scans the
// loaded entries circularly from the one after the last served, grants the
// first with time left min(quantum, remaining) and subtracts it, or returns
// finished when none has time left. A quantum of zero acts as one. The rams
// give one read per cycle, which sets the scan and copy speed. A new word
// is taken the cycle after the result enters the output register, even while
// that result waits. No clearing pass after reset. The user must write the
// quantum register through cfg_we / cfg_wdata only while the block is idle;
// the block itself does not enforce it.
module round_robin_slice_scheduler_unit #(
	parameter int MAX_PROCESSES = rrss_pkg::MAX_PROCESSES_DEF,
	parameter int TIME_WIDTH    = rrss_pkg::TIME_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rrss_in_if.sink                        item,
	rrss_out_if.source                     result,
	input  logic                           cfg_we,
	input  logic [rrss_pkg::QUANTUM_W-1:0] cfg_wdata
);
	import rrss_pkg::*;

	localparam int IW = $clog2(MAX_PROCESSES);

	logic [QUANTUM_W-1:0]  quantum_q;
	logic [QUANTUM_W-1:0]  quantum_eff;
	logic                  out_valid_q;
	res_t                  out_q;
	logic                  out_free;
	logic                  res_valid;
	res_t                  res;
	logic                  req_we;
	logic                  rem_we;
	logic [IW-1:0]         wr_addr;
	logic [TIME_WIDTH-1:0] wr_data;
	logic                  req_re;
	logic                  rem_re;
	logic [IW-1:0]         rd_addr;
	logic [TIME_WIDTH-1:0] req_rdata;
	logic [TIME_WIDTH-1:0] rem_rdata;

	// quantum register, zero acts as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RST;
		end else if (cfg_we) begin
			quantum_q <= cfg_wdata;
		end
	end

	assign quantum_eff = (quantum_q == '0) ? QUANTUM_W'(1) : quantum_q;

	// process table: required and remaining times
	rrss_ram #(.WIDTH(TIME_WIDTH), .DEPTH(MAX_PROCESSES)) u_req_ram (
		.clk   (clk),
		.we    (req_we),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (req_re),
		.raddr (rd_addr),
		.rdata (req_rdata)
	);

	rrss_ram #(.WIDTH(TIME_WIDTH), .DEPTH(MAX_PROCESSES)) u_rem_ram (
		.clk   (clk),
		.we    (rem_we),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rem_re),
		.raddr (rd_addr),
		.rdata (rem_rdata)
	);

	// operation sequencer
	rrss_seq #(.MAX_PROCESSES(MAX_PROCESSES), .TIME_WIDTH(TIME_WIDTH)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.operation (item.operation),
		.cpu_time  (item.cpu_time),
		.quantum   (quantum_eff),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.req_we    (req_we),
		.rem_we    (rem_we),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.req_re    (req_re),
		.rem_re    (rem_re),
		.rd_addr   (rd_addr),
		.req_rdata (req_rdata),
		.rem_rdata (rem_rdata)
	);

	// output register
	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.process_id = out_q.process_id;
	assign result.run_time   = out_q.run_time;
	assign result.finished   = out_q.finished;
	assign result.table_full = out_q.table_full;

endmodule

/* bench/rrss_sched_checker.sv */
`timescale 1ns / 1ps
// scoreboard of the round-robin slice scheduler: watches both channels and the
// quantum port, predicts every result word and compares it field by field
// depends on rrss_pkg, rrss_in_if and rrss_out_if
module rrss_sched_checker #(
	parameter int MAX_PROCESSES = rrss_pkg::MAX_PROCESSES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rrss_in_if                             item,
	rrss_out_if                            result,
	input  logic                           cfg_we,
	input  logic [rrss_pkg::QUANTUM_W-1:0] cfg_wdata,
	output int                             fail_count,
	output int                             words_pending
);
	import rrss_pkg::*;

	// shadow copy of the process table and the quantum
	logic [RUN_W-1:0]     need_time [MAX_PROCESSES];
	logic [RUN_W-1:0]     left_time [MAX_PROCESSES];
	int unsigned          loaded;
	int unsigned          next_slot;
	logic [QUANTUM_W-1:0] slice_len;
	res_t                 grant_queue [$];

	// apply one accepted word to the shadow table and return its result
	function automatic res_t schedule_word(logic [OP_W-1:0] op, logic [CPU_W-1:0] cpu);
		res_t             r;
		logic [RUN_W-1:0] q;
		logic [RUN_W-1:0] g;
		int unsigned      start;
		int unsigned      pos;
		r = '0;
		q = (slice_len == '0) ? RUN_W'(1) : RUN_W'(slice_len);
		case (op)
			OP_LOAD: begin
				if (loaded >= MAX_PROCESSES) begin
					r.table_full = 1'b1;
				end else begin
					need_time[loaded] = cpu;
					left_time[loaded] = cpu;
					r.process_id = PID_W'(loaded);
					loaded++;
				end
			end
			OP_RESTORE: begin
				for (int i = 0; i < loaded; i++)
					left_time[i] = need_time[i];
			end
			OP_NEXT: begin
				// scan restarts at entry 0 once the position runs past the table
				start = (next_slot < loaded) ? next_slot : 0;
				r.finished = 1'b1;
				for (int i = 0; i < loaded; i++) begin
					pos = (start + i) % loaded;
					if (left_time[pos] != '0) begin
						g = (left_time[pos] < q) ? left_time[pos] : q;
						left_time[pos] = left_time[pos] - g;
						next_slot = (pos + 1 >= MAX_PROCESSES) ? 0 : pos + 1;
						r.process_id = PID_W'(pos);
						r.run_time = g;
						r.finished = 1'b0;
						break;
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// predict on accept, compare on result handshake
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			loaded = 0;
			next_slot = 0;
			slice_len = QUANTUM_RST;
			grant_queue.delete();
		end else begin
			if (cfg_we)
				slice_len = cfg_wdata;
			if (result.valid && result.ready) begin
				if (grant_queue.size() == 0) begin
					$error("result word with none expected: process_id %0d run_time %0d",
						result.process_id, result.run_time);
					fail_count++;
				end else begin
					want = grant_queue.pop_front();
					if (result.process_id !== want.process_id) begin
						$error("process_id: expected %0d, got %0d",
							want.process_id, result.process_id);
						fail_count++;
					end
					if (result.run_time !== want.run_time) begin
						$error("run_time: expected %0d, got %0d", want.run_time, result.run_time);
						fail_count++;
					end
					if (result.finished !== want.finished) begin
						$error("finished: expected %0b, got %0b", want.finished, result.finished);
						fail_count++;
					end
					if (result.table_full !== want.table_full) begin
						$error("table_full: expected %0b, got %0b",
							want.table_full, result.table_full);
						fail_count++;
					end
				end
			end
			if (item.valid && item.ready)
				grant_queue.push_back(schedule_word(item.operation, item.cpu_time));
		end
		words_pending = grant_queue.size();
	end

endmodule

/* bench/tb_round_robin_slice_scheduler_unit.sv */
`timescale 1ns / 1ps
// top of the scheduler bench: clock, reset, word and quantum stimulus, result
// back-pressure and the verdict; checking lives in rrss_sched_checker
// depends on rrss_pkg, rrss_in_if, rrss_out_if, the scheduler and the checker
module tb_round_robin_slice_scheduler_unit;
	import rrss_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int RANDOM_WORDS = 1150;
	localparam int PHASES       = 8;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [QUANTUM_W-1:0] cfg_wdata = '0;
	logic                 in_fire = 1'b0;
	int                   fail_count;
	int                   words_pending;
	int unsigned          cycle_count = 0;

	rrss_in_if  item ();
	rrss_out_if result ();

	initial begin
		item.valid = 1'b0;
		item.operation = '0;
		item.cpu_time = '0;
		result.ready = 1'b0;
	end

	always #2 clk = ~clk;

	round_robin_slice_scheduler_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	rrss_sched_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.result        (result),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.words_pending (words_pending)
	);

	// word accepted at the last rising edge
	always @(posedge clk)
		in_fire <= item.valid && item.ready;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// offer one word from a falling edge and hold it until taken
	task automatic send_word(input logic [OP_W-1:0] op, input logic [CPU_W-1:0] cpu);
		item.valid <= 1'b1;
		item.operation <= op;
		item.cpu_time <= cpu;
		do @(negedge clk); while (!in_fire);
	endtask

	// quantum write once every result is back
	task automatic set_slice(input logic [QUANTUM_W-1:0] q);
		item.valid <= 1'b0;
		while (words_pending != 0) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= q;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// result back-pressure: segments of steady, random and sparse ready,
	// with a long hold-off every so often so the block backs up
	initial begin
		int unsigned span;
		int unsigned mode;
		int unsigned segments;
		segments = 0;
		@(posedge arst_n);
		forever begin
			segments++;
			if (segments % 40 == 0) begin
				result.ready <= 1'b0;
				span = 300 + $urandom_range(200);
				repeat (span) @(negedge clk);
			end else begin
				mode = $urandom_range(2);
				span = $urandom_range(60, 10);
				repeat (span) begin
					case (mode)
						0: result.ready <= 1'b1;
						1: result.ready <= 1'($urandom_range(1));
						default: result.ready <= ($urandom_range(3) == 0);
					endcase
					@(negedge clk);
				end
			end
		end
	end

	// word stimulus
	initial begin
		logic [QUANTUM_W-1:0] slice_plan [PHASES];
		logic [OP_W-1:0]      op;
		logic [CPU_W-1:0]     cpu;
		int unsigned          pick;
		int unsigned          burst;
		int unsigned          gap;
		int                   sent;
		slice_plan = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd128, 8'd2, 8'd16, 8'd7};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty table: unused code, finished scan, restore of nothing
		send_word(OP_UNUSED, 16'hFFFF);
		send_word(OP_NEXT, 16'hFFFF);
		send_word(OP_RESTORE, 16'h0000);
		// entry with no time leaves nothing to grant
		send_word(OP_LOAD, 16'h0000);
		send_word(OP_NEXT, 16'h0000);
		send_word(OP_LOAD, 16'h0003);
		send_word(OP_LOAD, 16'h0001);
		send_word(OP_LOAD, 16'h0005);
		// round robin with partial slices and the scan running off the end
		repeat (5) send_word(OP_NEXT, 16'h5A5A);
		send_word(OP_RESTORE, 16'hFFFF);
		// widest quantum takes whole remainders
		set_slice(8'd255);
		repeat (3) send_word(OP_NEXT, 16'hA5A5);
		// zero quantum acts as one
		set_slice(8'd0);
		send_word(OP_NEXT, 16'h0000);
		send_word(OP_LOAD, 16'h0004);
		send_word(OP_NEXT, 16'hFFFF);
		send_word(OP_UNUSED, 16'h0000);

		// random words in bursts, one quantum per phase
		foreach (slice_plan[p]) begin
			set_slice(slice_plan[p]);
			sent = 0;
			while (sent < RANDOM_WORDS / PHASES) begin
				burst = $urandom_range(16, 1);
				repeat (burst) begin
					pick = $urandom_range(99);
					cpu = CPU_W'($urandom);
					if (pick < 78) begin
						op = OP_NEXT;
					end else if (pick < 90) begin
						op = OP_LOAD;
						// mostly short jobs so the table drains now and then
						if ($urandom_range(19) != 0)
							cpu = CPU_W'($urandom_range(9));
					end else if (pick < 95) begin
						op = OP_RESTORE;
					end else begin
						op = OP_UNUSED;
					end
					send_word(op, cpu);
					sent++;
				end
				gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(8, 1);
				if (gap != 0) begin
					item.valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
		end

		// drain and verdict
		item.valid <= 1'b0;
		while (words_pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
